### rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the selectable moving average: window
// select codes, Q16 gain coefficients, datapath widths and the controller
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

    // Width of the window select register and of the audio words.
    localparam int LEVEL_W  = 3;
    localparam int SAMPLE_W = 16;

    // Window select codes. Codes below the short window act as the short
    // window and codes above the long window act as the long window.
    localparam logic [LEVEL_W-1:0] LEVEL_SHORT = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_MID   = 3'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_LONG  = 3'd6;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_MID;

    // Tap counts of the three windows.
    localparam int TAPS_W = 5;
    localparam logic [TAPS_W-1:0] TAPS_SHORT = 5'd8;
    localparam logic [TAPS_W-1:0] TAPS_MID   = 5'd16;
    localparam logic [TAPS_W-1:0] TAPS_LONG  = 5'd24;

    // Q16 coefficients, each 0.8 divided by the window length.
    localparam int COEF_W = 13;
    localparam logic [COEF_W-1:0] COEF_SHORT = 13'd6554;
    localparam logic [COEF_W-1:0] COEF_MID   = 13'd3277;
    localparam logic [COEF_W-1:0] COEF_LONG  = 13'd2185;

    // At most 24 samples are summed, so 21 signed bits always hold the sum.
    localparam int SUM_W  = 21;
    localparam int PROD_W = SUM_W + COEF_W + 1;
    localparam int FRAC_W = 16;
    localparam int RES_W  = PROD_W - FRAC_W;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // Output range of the scaled average.
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd26216;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd26215;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_STORE,
        ST_EMIT
    } sma_state_t;

    function automatic logic [TAPS_W-1:0] taps_of(input logic [LEVEL_W-1:0] level);
        logic [TAPS_W-1:0] taps;
        unique case (level) inside
            [3'd0:LEVEL_SHORT]: taps = TAPS_SHORT;
            LEVEL_MID:          taps = TAPS_MID;
            default:            taps = TAPS_LONG;
        endcase
        return taps;
    endfunction

    function automatic logic [COEF_W-1:0] coef_of(input logic [LEVEL_W-1:0] level);
        logic [COEF_W-1:0] coef;
        unique case (level) inside
            [3'd0:LEVEL_SHORT]: coef = COEF_SHORT;
            LEVEL_MID:          coef = COEF_MID;
            default:            coef = COEF_LONG;
        endcase
        return coef;
    endfunction

endpackage

`default_nettype wire

### rtl/selectable_moving_average.sv
// ----------------------------------------------------------------------------
// selectable_moving_average
// Moving average over 8, 16 or 24 audio samples with a gain of 0.8, built
// around one synchronous delay-line memory that one read port walks per word.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                  Direction  Carries
//  s_       s_valid, s_ready, s_sample_in          in         audio sample
//  m_       m_valid, m_ready, m_smoothed_out       out        scaled average
//  cfg_     cfg_valid, cfg_ready, cfg_data         in         window select
//
// A new sample is accepted only once the last word is done. With T the
// window length (8, 16 or 24), the walk reads T - 1 entries of the delay-line
// memory one entry a cycle through its single read port; then one step takes
// the last read, one writes the new sample and multiplies, and one loads the
// output register. A stalled output holds the controller in its last step.
// Reset is synchronous and active low and takes effect at once; per-entry
// valid bits make the whole delay line read as zero after reset.
//
`default_nettype none

module selectable_moving_average #(
    parameter int MAX_TAPS = 24
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [sma_pkg::SAMPLE_W-1:0] s_sample_in,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [sma_pkg::SAMPLE_W-1:0]      m_smoothed_out,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sma_pkg::LEVEL_W-1:0]         cfg_data
);

    import sma_pkg::*;

    // The delay line holds the past samples; entry 0 is the most recent.
    localparam int DEPTH  = MAX_TAPS - 1;
    localparam int ADDR_W = $clog2(DEPTH);

    sma_state_t state_reg, state_next;

    logic [LEVEL_W-1:0] level_reg;

    // Per-word working registers.
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [COEF_W-1:0]          coef_reg;
    logic [ADDR_W-1:0]          rd_addr_reg;
    logic [ADDR_W-1:0]          rd_last_reg;
    logic [ADDR_W-1:0]          top_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    // Read pipeline: data, its address and its valid bit are registered and
    // arrive in the cycle after the read is issued.
    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    written_reg;
    logic [SAMPLE_W-1:0] rdata_reg;
    logic                rwritten_reg;
    logic                dvld_reg;
    logic [ADDR_W-1:0]   daddr_reg;

    logic m_valid_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    // Controller outputs.
    logic accept;
    logic rd_en;
    logic store_en;
    logic load_out;
    logic out_free;

    // Window geometry for the word being accepted.
    logic [ADDR_W-1:0] rd_last_next;
    logic [ADDR_W-1:0] top_next;

    // Write port and datapath.
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [SAMPLE_W-1:0]        wr_data;
    logic signed [SAMPLE_W-1:0] tap_val;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [RES_W-1:0]    scaled;
    logic signed [SAMPLE_W-1:0] result;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Controller: next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rd_addr_reg == rd_last_reg) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_STORE;
            ST_STORE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: outputs.
    // ------------------------------------------------------------------
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        store_en = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready  = 1'b1;
            ST_WALK:  rd_en    = 1'b1;
            ST_LAST:  ;
            ST_STORE: store_en = 1'b1;
            ST_EMIT:  load_out = out_free;
            default:  ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The user must write the window select only while no word is in flight; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            level_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Window geometry. With a window of Tc taps (cut to MAX_TAPS), the sum
    // reads entries 0 .. Tc-2, and the shift moves entries up to Tc-1, but
    // never past the end of the delay line.
    // ------------------------------------------------------------------
    always_comb begin
        int taps;
        int tc;
        taps = int'(taps_of(level_reg));
        tc   = (taps > MAX_TAPS) ? MAX_TAPS : taps;
        rd_last_next = ADDR_W'(tc - 2);
        top_next     = (tc == MAX_TAPS) ? ADDR_W'(tc - 2) : ADDR_W'(tc - 1);
    end

    // ------------------------------------------------------------------
    // Delay-line memory. The read and the write of one cycle may hit the
    // same entry while the walk shifts; the read then returns the old
    // contents, which is exactly the value the walk needs next.
    // ------------------------------------------------------------------
    assign tap_val = rwritten_reg ? $signed(rdata_reg) : '0;

    always_comb begin
        if (store_en) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = x_reg;
        end else begin
            wr_en   = dvld_reg && (daddr_reg < top_reg);
            wr_addr = daddr_reg + ADDR_W'(1);
            wr_data = tap_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            dvld_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            dvld_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rwritten_reg <= written_reg[rd_addr_reg];
            daddr_reg    <= rd_addr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Accumulate, multiply and round.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg       <= s_sample_in;
            sum_reg     <= SUM_W'(s_sample_in);
            coef_reg    <= coef_of(level_reg);
            rd_addr_reg <= '0;
            rd_last_reg <= rd_last_next;
            top_reg     <= top_next;
        end else begin
            if (rd_en) begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
            end
            if (dvld_reg) begin
                sum_reg <= sum_reg + SUM_W'(tap_val);
            end
        end
        if (store_en) begin
            prod_reg <= sum_reg * $signed({1'b0, coef_reg});
        end
    end

    // Adding one half and dropping the fraction with an arithmetic shift
    // rounds half up; the result is then clamped to the output range.
    assign rounded = prod_reg + ROUND_HALF;
    assign scaled  = rounded[PROD_W-1:FRAC_W];

    always_comb begin
        if (scaled < OUT_MIN) begin
            result = OUT_MIN;
        end else if (scaled > OUT_MAX) begin
            result = OUT_MAX;
        end else begin
            result = scaled[SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished word while the next word is
    // accepted and walked.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_smoothed_out = out_reg;

endmodule

`default_nettype wire

### rtl/sma_checker.sv
// ----------------------------------------------------------------------------
// sma_checker
// Port-level checks of the selectable moving average, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [sma_pkg::SAMPLE_W-1:0] m_smoothed_out
);

    import sma_pkg::*;

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_smoothed_out))
        else $error("result word changed while stalled");

    // The block works on one word at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in flight");

    // Every delivered result lies within the clamped output range.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_smoothed_out >= OUT_MIN) && (m_smoothed_out <= OUT_MAX))
        else $error("result word outside the output range");

    // No result appears in the cycle right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word offered right after reset");

endmodule

bind selectable_moving_average sma_checker u_sma_checker (.*);

`default_nettype wire

### test/selectable_moving_average_test.sv
// ----------------------------------------------------------------------------
// selectable_moving_average_test
// Self-checking testbench for the selectable moving average. A clocked
// driver offers audio samples from a queue, a clocked receiver takes the
// scaled averages with random stalls, and a monitor predicts each result
// from its own delay line and window select and compares it with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module selectable_moving_average_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sma_pkg::*;

    // Length of the delay line behind the newest sample.
    localparam int HIST_DEPTH = 23;

    // Window select codes outside the legal range. The block folds them onto
    // the nearest legal window, and the run writes them to prove it.
    localparam logic [LEVEL_W-1:0] LEVEL_BELOW = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ABOVE = 3'd7;

    // Run length and pacing. The long window makes the slowest word in the
    // block, each side adds its drawn waits and now and then a long output hold,
    // so the cycle limit leaves a wide margin over a few hundred words.
    localparam int LIMIT_CYCLES  = 500000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int LONG_HOLD     = 250;
    localparam int PHASE_WORDS   = 50;
    localparam int MAX_WAIT      = 12;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in    = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0] m_smoothed_out;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic [LEVEL_W-1:0]         cfg_data       = LEVEL_RESET;

    // Samples waiting to be offered and averages still owed by the block.
    logic signed [SAMPLE_W-1:0] pending_samples[$];
    logic signed [SAMPLE_W-1:0] expected_smoothed[$];

    // Our own copy of the block's state: the past samples and the window.
    logic signed [SAMPLE_W-1:0] hist_mem[HIST_DEPTH];
    logic [LEVEL_W-1:0]         model_level = LEVEL_RESET;

    // Handshakes seen at the last rising edge, for the falling-edge drivers.
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    int samples_issued = 0;
    int samples_taken  = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int send_gap       = 0;
    int recv_stall     = 0;
    int hold_left      = 0;

    // When set, neither side draws a wait, so words are offered back to back.
    logic no_idle = 1'b0;

    selectable_moving_average i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_smoothed_out (m_smoothed_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Averages the new sample with the window's worth of past samples, scales
    // by 0.8 over the window in Q16 with round half up, and clamps to the
    // output range. Then the sample is shifted into the window's part of the
    // delay line only; deeper entries keep their stale values for a later,
    // longer window.
    function automatic logic signed [SAMPLE_W-1:0] smooth_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        int     taps;
        int     top;
        longint coef;
        longint acc;
        longint scaled;
        if (model_level <= LEVEL_SHORT) begin
            taps = int'(TAPS_SHORT);
            coef = longint'(COEF_SHORT);
        end else if (model_level == LEVEL_MID) begin
            taps = int'(TAPS_MID);
            coef = longint'(COEF_MID);
        end else begin
            taps = int'(TAPS_LONG);
            coef = longint'(COEF_LONG);
        end
        acc = longint'(x);
        for (int k = 0; k < taps - 1 && k < HIST_DEPTH; k++) begin
            acc += longint'(hist_mem[k]);
        end
        // An arithmetic shift of a signed value is a floor division.
        scaled = (acc * coef + 64'sd32768) >>> 16;
        if (scaled < longint'(OUT_MIN)) begin
            scaled = longint'(OUT_MIN);
        end else if (scaled > longint'(OUT_MAX)) begin
            scaled = longint'(OUT_MAX);
        end
        top = (taps - 1 > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : taps - 1;
        for (int k = top; k > 0; k--) begin
            hist_mem[k] = hist_mem[k - 1];
        end
        hist_mem[0] = x;
        return SAMPLE_W'(scaled);
    endfunction

    // Monitor: samples every handshake at the rising edge. Accepted samples
    // feed the prediction, accepted results are checked against the oldest
    // prediction still outstanding.
    always @(posedge aclk) begin : monitor
        logic signed [SAMPLE_W-1:0] want;
        in_taken  <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                model_level = cfg_data;
            end
            if (s_valid && s_ready) begin
                expected_smoothed.push_back(smooth_sample(s_sample_in));
                samples_taken <= samples_taken + 1;
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_smoothed.size() == 0) begin
                    $display("%t: expected no word, got smoothed_out %0d",
                             $time, m_smoothed_out);
                    error_count++;
                end else begin
                    want = expected_smoothed.pop_front();
                    if (m_smoothed_out !== want) begin
                        $display("%t: smoothed_out expected %0d, got %0d",
                                 $time, want, m_smoothed_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // Sender: holds a word until it is taken, then waits its drawn gap
    // before offering the next one from the queue.
    always @(negedge aclk) begin : sender
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && !in_taken) begin
            // The word on the bus has not been taken yet; leave it alone.
        end else if (send_gap != 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_samples.size() != 0) begin
            s_valid     <= 1'b1;
            s_sample_in <= pending_samples.pop_front();
            send_gap    <= no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: after each result it stalls for a drawn number of cycles.
    // Twice in the run it holds off for a long stretch instead, so the block
    // backs up and has to stall the sender.
    always @(negedge aclk) begin : receiver
        int draw;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
            hold_left  <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= (hold_left == 1);
            hold_left <= hold_left - 1;
        end else if (out_taken && (results_seen == 60 || results_seen == 300)) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
        end else if (out_taken) begin
            draw       = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            m_ready    <= (draw == 0);
            recv_stall <= draw;
        end else if (recv_stall != 0) begin
            m_ready    <= (recv_stall == 1);
            recv_stall <= recv_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // The run ends here if the block stops answering.
    initial begin : watchdog
        for (int cycles = 0; cycles < LIMIT_CYCLES; cycles++) begin
            @(posedge aclk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] x);
        pending_samples.push_back(x);
        samples_issued++;
    endtask

    // Returns once every queued word was taken and every result came back.
    task automatic wait_drained();
        while (samples_taken != samples_issued || expected_smoothed.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // The window select is only changed while the block has nothing in flight.
    task automatic write_level(input logic [LEVEL_W-1:0] lvl);
        wait_drained();
        @(negedge aclk);
        cfg_data  <= lvl;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Fills one phase with runs of samples of one kind. Runs of full-scale
    // values can fill whole windows, driving the long window past the output
    // range and into saturation; random and small runs exercise the rounding.
    task automatic queue_phase(input int count);
        int run;
        int kind;
        int left;
        left = count;
        while (left > 0) begin
            run  = $urandom_range(1, 30);
            kind = $urandom_range(0, 4);
            if (run > left) begin
                run = left;
            end
            for (int i = 0; i < run; i++) begin
                case (kind)
                    0: begin
                        queue_sample(SAMPLE_W'($urandom));
                    end
                    1: begin
                        queue_sample(SAMPLE_MAX);
                    end
                    2: begin
                        queue_sample(SAMPLE_MIN);
                    end
                    3: begin
                        queue_sample(SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 200)));
                    end
                    default: begin
                        queue_sample(SAMPLE_W'($urandom_range(0, 200)) - 16'sd100);
                    end
                endcase
            end
            left -= run;
        end
    endtask

    initial begin : stimulus
        logic [LEVEL_W-1:0] level_plan[10] = '{
            LEVEL_LONG, LEVEL_BELOW, LEVEL_ABOVE, LEVEL_MID, LEVEL_SHORT,
            LEVEL_LONG, LEVEL_MID, LEVEL_ABOVE, LEVEL_SHORT, LEVEL_LONG
        };
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_mem[k] = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset window: zero, unit steps, both full-scale
        // values and alternating bit patterns.
        queue_sample(16'sd0);
        queue_sample(16'sd1);
        queue_sample(-16'sd1);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(16'sh5555);
        queue_sample(16'shaaaa);

        // Short window filled with full scale in both directions, which lands
        // exactly on the ends of the output range.
        write_level(LEVEL_SHORT);
        repeat (8) queue_sample(SAMPLE_MAX);
        repeat (8) queue_sample(SAMPLE_MIN);

        // Random part: one phase per window setting, the out-of-range codes
        // among them. Some phases run with no idling on either side.
        for (int p = 0; p < 10; p++) begin
            write_level(level_plan[p]);
            no_idle = (p == 2) || ($urandom_range(0, 3) == 0);
            queue_phase(PHASE_WORDS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
